// File: rtl/rtfges_pkg.sv
// Shared types and constants for the RTF group extent scanner.
package rtfges_pkg;

	localparam int DEPTH_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_I      = 8'h69;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;

	typedef enum logic [2:0] {
		MODE_OUTSIDE = 3'd0,
		MODE_NORMAL  = 3'd1,
		MODE_ESC     = 3'd2,
		MODE_ESC_B   = 3'd3,
		MODE_ESC_BI  = 3'd4,
		MODE_DIGITS  = 3'd5,
		MODE_BINARY  = 3'd6
	} mode_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_doc;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       inside_res;
		logic       end_mark;
	} out_item_t;

endpackage

// File: rtl/rtf_group_extent_scanner.sv
// RTF group extent scanner: brace depth tracking with escape and bin-count skip.
//
//  channel  dir  handshake                   payload
//  item     in   item_valid / item_ready     rtfges_pkg::in_item_t
//  result   out  result_valid / result_ready rtfges_pkg::out_item_t
//
// One item per cycle while result_ready allows: the scan state updates at the accepting
// edge and the result lands in an output register the same edge.
// A full output register is refilled in the cycle it drains; item_ready only
// drops while the result is held by result_ready low.
// Reset puts the scanner outside any document with depth and count at zero.
module rtf_group_extent_scanner #(
	parameter int DEPTH_WIDTH = rtfges_pkg::DEPTH_WIDTH_DEF,
	parameter int COUNT_WIDTH = rtfges_pkg::COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  rtfges_pkg::in_item_t  item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output rtfges_pkg::out_item_t result
);

	rtfges_pkg::mode_t        mode_q, mode_d;
	logic [DEPTH_WIDTH-1:0]   depth_q, depth_d, depth_dec;
	logic [COUNT_WIDTH-1:0]   skip_q, skip_d;
	logic [COUNT_WIDTH+3:0]   skip_ext, skip_mac;
	logic                     inside_d, end_d, do_plain, accept;
	logic                     result_valid_q;
	rtfges_pkg::out_item_t    result_q;
	logic [7:0]               b;

	assign b          = item.data_byte;
	assign item_ready = !result_valid_q || result_ready;
	assign accept     = item_valid && item_ready;

	// skip*10 + digit, with headroom to detect saturation
	assign skip_ext = {4'b0000, skip_q};
	assign skip_mac = (skip_ext << 3) + (skip_ext << 1) + (COUNT_WIDTH+4)'(b[3:0]);

	always_comb begin
		mode_d    = mode_q;
		depth_d   = depth_q;
		skip_d    = skip_q;
		inside_d  = 1'b1;
		end_d     = 1'b0;
		do_plain  = 1'b0;
		depth_dec = (depth_q != '0) ? depth_q - DEPTH_WIDTH'(1) : depth_q;
		if (item.start_doc) begin
			mode_d  = rtfges_pkg::MODE_NORMAL;
			depth_d = DEPTH_WIDTH'(1);
			skip_d  = '0;
		end else begin
			case (mode_q)
				rtfges_pkg::MODE_NORMAL: begin
					do_plain = 1'b1;
				end
				rtfges_pkg::MODE_ESC: begin
					mode_d = (b == rtfges_pkg::CH_B) ? rtfges_pkg::MODE_ESC_B
						: rtfges_pkg::MODE_NORMAL;
				end
				rtfges_pkg::MODE_ESC_B: begin
					if (b == rtfges_pkg::CH_I) begin
						mode_d = rtfges_pkg::MODE_ESC_BI;
					end else begin
						mode_d   = rtfges_pkg::MODE_NORMAL;
						do_plain = 1'b1;
					end
				end
				rtfges_pkg::MODE_ESC_BI: begin
					if (b == rtfges_pkg::CH_N) begin
						mode_d = rtfges_pkg::MODE_DIGITS;
						skip_d = '0;
					end else begin
						mode_d   = rtfges_pkg::MODE_NORMAL;
						do_plain = 1'b1;
					end
				end
				rtfges_pkg::MODE_DIGITS: begin
					if (b inside {[rtfges_pkg::CH_0:rtfges_pkg::CH_9]}) begin
						if (skip_mac[COUNT_WIDTH+3:COUNT_WIDTH] != 4'b0000)
							skip_d = '1;
						else
							skip_d = skip_mac[COUNT_WIDTH-1:0];
					end else begin
						mode_d = (skip_q != '0) ? rtfges_pkg::MODE_BINARY
							: rtfges_pkg::MODE_NORMAL;
					end
				end
				rtfges_pkg::MODE_BINARY: begin
					if (skip_q != '0)
						skip_d = skip_q - COUNT_WIDTH'(1);
					if (skip_d == '0)
						mode_d = rtfges_pkg::MODE_NORMAL;
				end
				default: begin
					mode_d   = rtfges_pkg::MODE_OUTSIDE;
					inside_d = 1'b0;
				end
			endcase
		end
		if (do_plain) begin
			if (b == rtfges_pkg::CH_BSLASH) begin
				mode_d = rtfges_pkg::MODE_ESC;
			end else if (b == rtfges_pkg::CH_LBRACE) begin
				if (depth_q != '1)
					depth_d = depth_q + DEPTH_WIDTH'(1);
			end else if (b == rtfges_pkg::CH_RBRACE) begin
				depth_d = depth_dec;
				if (depth_dec == '0) begin
					mode_d = rtfges_pkg::MODE_OUTSIDE;
					end_d  = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= rtfges_pkg::MODE_OUTSIDE;
			depth_q        <= '0;
			skip_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q         <= mode_d;
				depth_q        <= depth_d;
				skip_q         <= skip_d;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.out_byte   <= b;
			result_q.inside_res <= inside_d;
			result_q.end_mark   <= end_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// outside a document exactly when depth is zero
	a_depth_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == rtfges_pkg::MODE_OUTSIDE) == (depth_q == '0))
		else $error("depth and mode disagree");

	a_binary_count: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == rtfges_pkg::MODE_BINARY) |-> (skip_q != '0))
		else $error("binary skip with zero count");

	a_end_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.end_mark) |-> result.inside_res)
		else $error("end mark outside the group");

	a_end_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_d) |=> (mode_q == rtfges_pkg::MODE_OUTSIDE))
		else $error("end brace did not leave the document");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result)))
		else $error("stalled result lost");

endmodule

// File: tb/rtf_group_extent_scanner_test.sv
// Self-checking testbench for the RTF group extent scanner: directed and random byte streams.
`timescale 1ns / 100ps

module rtf_group_extent_scanner_test;

	localparam int STOP_CYCLES = 1000000;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_ITEMS = 1400;
	localparam logic [rtfges_pkg::DEPTH_WIDTH_DEF-1:0] DEPTH_MAX = '1;
	localparam logic [rtfges_pkg::COUNT_WIDTH_DEF-1:0] COUNT_MAX = '1;

	typedef struct {
		rtfges_pkg::in_item_t pay;
		bit                   drain;
	} queued_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	rtfges_pkg::in_item_t  item = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	rtfges_pkg::out_item_t result;

	queued_t               stim_q[$];
	rtfges_pkg::out_item_t marked_q[$];

	// scanner state as the block should hold it
	rtfges_pkg::mode_t                     sc_mode = rtfges_pkg::MODE_OUTSIDE;
	logic [rtfges_pkg::DEPTH_WIDTH_DEF-1:0] sc_depth = '0;
	logic [rtfges_pkg::COUNT_WIDTH_DEF-1:0] sc_count = '0;

	int  errors = 0;
	int  cycles = 0;
	int  bytes_in = 0;
	int  checked = 0;
	int  total_items = 0;
	bit  item_taken = 0;
	int  rand_base, quiet_lo, quiet_hi;
	int  hold_at[2];
	int  hold_idx = 0;
	int  stall_left = 0;

	rtf_group_extent_scanner dut (
		.clk,
		.arst_n,
		.item_valid,
		.item_ready,
		.item,
		.result_valid,
		.result_ready,
		.result
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------- prediction ----------------

	function automatic bit brace_scan(logic [7:0] b);
		bit closed;
		closed = 0;
		if (b == rtfges_pkg::CH_BSLASH) begin
			sc_mode = rtfges_pkg::MODE_ESC;
		end else if (b == rtfges_pkg::CH_LBRACE) begin
			if (sc_depth != DEPTH_MAX)
				sc_depth++;
		end else if (b == rtfges_pkg::CH_RBRACE) begin
			if (sc_depth != 0)
				sc_depth--;
			if (sc_depth == 0) begin
				sc_mode = rtfges_pkg::MODE_OUTSIDE;
				closed = 1;
			end
		end
		return closed;
	endfunction

	function automatic rtfges_pkg::out_item_t mark_byte(rtfges_pkg::in_item_t it);
		rtfges_pkg::out_item_t r;
		logic [7:0] b;
		logic [rtfges_pkg::COUNT_WIDTH_DEF-1:0] d;
		b = it.data_byte;
		r.out_byte = b;
		r.inside_res = 1'b1;
		r.end_mark = 1'b0;
		if (it.start_doc) begin
			sc_mode = rtfges_pkg::MODE_NORMAL;
			sc_depth = rtfges_pkg::DEPTH_WIDTH_DEF'(1);
			sc_count = '0;
		end else begin
			case (sc_mode)
				rtfges_pkg::MODE_NORMAL: begin
					r.end_mark = brace_scan(b);
				end
				rtfges_pkg::MODE_ESC: begin
					sc_mode = (b == rtfges_pkg::CH_B) ? rtfges_pkg::MODE_ESC_B
						: rtfges_pkg::MODE_NORMAL;
				end
				rtfges_pkg::MODE_ESC_B: begin
					if (b == rtfges_pkg::CH_I) begin
						sc_mode = rtfges_pkg::MODE_ESC_BI;
					end else begin
						sc_mode = rtfges_pkg::MODE_NORMAL;
						r.end_mark = brace_scan(b);
					end
				end
				rtfges_pkg::MODE_ESC_BI: begin
					if (b == rtfges_pkg::CH_N) begin
						sc_mode = rtfges_pkg::MODE_DIGITS;
						sc_count = '0;
					end else begin
						sc_mode = rtfges_pkg::MODE_NORMAL;
						r.end_mark = brace_scan(b);
					end
				end
				rtfges_pkg::MODE_DIGITS: begin
					if (b >= rtfges_pkg::CH_0 && b <= rtfges_pkg::CH_9) begin
						d = rtfges_pkg::COUNT_WIDTH_DEF'(b - rtfges_pkg::CH_0);
						// saturate instead of wrapping
						if (sc_count > (COUNT_MAX - d) / 10)
							sc_count = COUNT_MAX;
						else
							sc_count = sc_count * 10 + d;
					end else begin
						sc_mode = (sc_count != 0) ? rtfges_pkg::MODE_BINARY
							: rtfges_pkg::MODE_NORMAL;
					end
				end
				rtfges_pkg::MODE_BINARY: begin
					if (sc_count != 0)
						sc_count--;
					if (sc_count == 0)
						sc_mode = rtfges_pkg::MODE_NORMAL;
				end
				default: begin
					sc_mode = rtfges_pkg::MODE_OUTSIDE;
					r.inside_res = 1'b0;
				end
			endcase
		end
		return r;
	endfunction

	// ---------------- stimulus ----------------

	task automatic add_byte(logic [7:0] b, bit sd = 0, bit drain = 0);
		queued_t q;
		q.pay.data_byte = b;
		q.pay.start_doc = sd;
		q.drain = drain;
		stim_q.push_back(q);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do
			b = any_byte();
		while (b == rtfges_pkg::CH_BSLASH || b == rtfges_pkg::CH_LBRACE
			|| b == rtfges_pkg::CH_RBRACE);
		return b;
	endfunction

	// payload of a bin run, heavy on bytes that would otherwise be scanned
	function automatic logic [7:0] bin_byte();
		case ($urandom_range(0, 7))
			0: return rtfges_pkg::CH_LBRACE;
			1: return rtfges_pkg::CH_RBRACE;
			2: return rtfges_pkg::CH_BSLASH;
			default: return any_byte();
		endcase
	endfunction

	function automatic logic [7:0] delim_byte();
		logic [7:0] b;
		if ($urandom_range(0, 2) != 0)
			return 8'h20;
		do
			b = bin_byte();
		while (b >= rtfges_pkg::CH_0 && b <= rtfges_pkg::CH_9);
		return b;
	endfunction

	task automatic add_bin_run();
		int k, n;
		k = $urandom_range(0, 19);
		if (k == 0)
			n = 0;
		else if (k < 16)
			n = $urandom_range(1, 12);
		else
			n = $urandom_range(13, 60);
		add_text("\\bin");
		if ($urandom_range(0, 3) == 0)
			add_byte(rtfges_pkg::CH_0);
		add_text($sformatf("%0d", n));
		add_byte(delim_byte());
		repeat (n) add_byte(bin_byte());
	endtask

	task automatic add_document(bit drain);
		int lvl, toks;
		bit cut;
		logic [7:0] b;
		add_byte(any_byte(), 1, drain);
		lvl = 1;
		cut = 0;
		toks = $urandom_range(3, 24);
		while (toks > 0 && !cut) begin
			toks--;
			case ($urandom_range(0, 11))
				0, 1, 2: repeat ($urandom_range(1, 4)) add_byte(text_byte());
				3: if (lvl < 6) begin
					add_byte(rtfges_pkg::CH_LBRACE);
					lvl++;
				end
				4: if (lvl > 1) begin
					add_byte(rtfges_pkg::CH_RBRACE);
					lvl--;
				end
				5: begin
					// escaped byte; b is left to the partial control word case
					do
						b = any_byte();
					while (b == rtfges_pkg::CH_B);
					add_byte(rtfges_pkg::CH_BSLASH);
					add_byte(b);
				end
				6: begin
					add_text($urandom_range(0, 1) ? "\\b" : "\\bi");
					if (lvl > 1 && $urandom_range(0, 1)) begin
						add_byte(rtfges_pkg::CH_RBRACE);
						lvl--;
					end else begin
						add_byte(rtfges_pkg::CH_LBRACE);
						lvl++;
					end
				end
				7, 8: add_bin_run();
				9: add_byte(any_byte());
				10: add_text("\\par ");
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						// saturating count, abandoned by the next start
						add_text("\\bin");
						add_text($sformatf("%0d%0d", $urandom_range(1, 99), $urandom));
						add_byte(delim_byte());
						repeat ($urandom_range(0, 5)) add_byte(bin_byte());
						cut = 1;
					end else begin
						add_byte(text_byte());
					end
				end
			endcase
		end
		if (!cut && $urandom_range(0, 14) != 0)
			repeat (lvl) add_byte(rtfges_pkg::CH_RBRACE);
		repeat ($urandom_range(0, 3)) add_byte(any_byte());
	endtask

	initial begin
		int doc_no;
		// bytes before any document
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(rtfges_pkg::CH_RBRACE);
		// start byte counts as the outer brace whatever its value
		add_byte(8'hFF, 1);
		// group, escaped brace, partial control words, zero count,
		// brace as delimiter, skipped binary, closing brace
		add_text("{\\{\\b{\\bi}\\bin0 \\bin2}{\\}}");

		// count saturation and restarts mid-document
		add_byte(rtfges_pkg::CH_LBRACE, 1, 1);
		add_text("\\bin4294967295x{}");
		add_byte(rtfges_pkg::CH_RBRACE, 1);
		add_text("\\bin99999999999 a");
		add_byte(8'h00, 1);
		add_text("}");

		// nested groups
		add_byte(rtfges_pkg::CH_LBRACE, 1);
		repeat (8) add_byte(rtfges_pkg::CH_LBRACE);
		add_text("}}");

		rand_base = stim_q.size();
		quiet_lo = rand_base + 300;
		quiet_hi = rand_base + 650;
		hold_at[0] = 12;
		hold_at[1] = rand_base + 900;
		doc_no = 0;
		while (stim_q.size() < rand_base + RAND_ITEMS) begin
			add_document(doc_no % 25 == 0);
			doc_no++;
		end
		total_items = stim_q.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (checked < total_items);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("rtf_group_extent_scanner regression: pass");
		else
			$display("rtf_group_extent_scanner regression: fail");
		$finish;
	end

	function automatic bit quiet();
		return bytes_in >= quiet_lo && bytes_in < quiet_hi;
	endfunction

	// ---------------- driver ----------------

	always @(negedge clk) begin
		queued_t nx;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_taken) begin
			if (stim_q.size() != 0 && !(stim_q[0].drain && marked_q.size() != 0)
					&& (quiet() || $urandom_range(0, 99) >= 23)) begin
				nx = stim_q.pop_front();
				item <= nx.pay;
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else if (hold_idx < 2 && bytes_in >= hold_at[hold_idx]) begin
			// long hold so the block backs up into its input
			stall_left <= HOLD_CYCLES;
			hold_idx <= hold_idx + 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= quiet() || $urandom_range(0, 99) >= 23;
		end
	end

	// ---------------- monitor ----------------

	always @(posedge clk) begin
		rtfges_pkg::out_item_t want;
		if (!arst_n) begin
			item_taken = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (marked_q.size() == 0) begin
					$error("result item with none expected: %p", result);
					errors++;
				end else begin
					want = marked_q.pop_front();
					checked++;
					if (result.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, got %h", want.out_byte, result.out_byte);
						errors++;
					end
					if (result.inside_res !== want.inside_res) begin
						$error("inside_res: expected %b, got %b", want.inside_res,
							result.inside_res);
						errors++;
					end
					if (result.end_mark !== want.end_mark) begin
						$error("end_mark: expected %b, got %b", want.end_mark, result.end_mark);
						errors++;
					end
				end
			end
			item_taken = item_valid && item_ready;
			if (item_taken) begin
				marked_q.push_back(mark_byte(item));
				bytes_in++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == STOP_CYCLES) begin
			$display("rtf_group_extent_scanner regression: fail");
			$finish;
		end
	end

endmodule
